/* src/pfrb_pkg.sv */
// Shared types and constants for the primed frame ring buffer.
`timescale 1ns / 1ps
`default_nettype none

package pfrb_pkg;

    localparam int DEPTH_DEFAULT = 16;

    typedef enum logic [1:0] {
        CMD_PUSH    = 2'd0,
        CMD_POP     = 2'd1,
        CMD_REPLACE = 2'd2,
        CMD_NONE    = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_FULL       = 3'd1,
        ST_NOT_PRIMED = 3'd2,
        ST_EMPTY      = 3'd3,
        ST_NO_KEY     = 3'd4
    } status_t;

    // One classified request handed from the front to the back.
    typedef struct packed {
        cmd_t        op;
        logic [63:0] data;
        logic [15:0] len;
        logic        given;
        logic [31:0] value;
    } req_t;

    typedef struct packed {
        status_t     status;
        logic [63:0] data;
        logic [15:0] len;
        logic [31:0] seq;
    } res_t;

endpackage

`default_nettype wire

/* src/pfrb_front.sv */
// Front end: accepts requests, classifies them and queues them for the back end.
`timescale 1ns / 1ps
`default_nettype none

module pfrb_front import pfrb_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    output logic              in_ready,
    input  wire logic [1:0]   in_cmd,
    input  wire logic [63:0]  in_data,
    input  wire logic [15:0]  in_len,
    input  wire logic         in_given,
    input  wire logic [31:0]  in_value,
    output logic              req_valid,
    input  wire logic         req_ready,
    output req_t              req
);

    req_t       q_reg [2];
    logic       q_wp_reg;
    logic       q_wp_next;
    logic       q_rp_reg;
    logic       q_rp_next;
    logic [1:0] q_cnt_reg;
    logic [1:0] q_cnt_next;
    logic       do_push;
    logic       do_pop;
    req_t       classified;

    // seq_given only matters on a push; drop it elsewhere
    always_comb
    begin
        classified.op    = cmd_t'(in_cmd);
        classified.data  = in_data;
        classified.len   = in_len;
        classified.given = in_given && (cmd_t'(in_cmd) == CMD_PUSH);
        classified.value = in_value;
    end

    assign in_ready  = (q_cnt_reg != 2'd2);
    assign req_valid = (q_cnt_reg != 2'd0);
    assign req       = q_reg[q_rp_reg];
    assign do_push   = in_valid && in_ready;
    assign do_pop    = req_valid && req_ready;

    always_comb
    begin
        q_wp_next  = do_push ? ~q_wp_reg : q_wp_reg;
        q_rp_next  = do_pop ? ~q_rp_reg : q_rp_reg;
        q_cnt_next = q_cnt_reg;
        if (do_push && !do_pop)
        begin
            q_cnt_next = q_cnt_reg + 2'd1;
        end
        else if (!do_push && do_pop)
        begin
            q_cnt_next = q_cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_wp_reg  <= 1'b0;
            q_rp_reg  <= 1'b0;
            q_cnt_reg <= 2'd0;
        end
        else
        begin
            q_wp_reg  <= q_wp_next;
            q_rp_reg  <= q_rp_next;
            q_cnt_reg <= q_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_reg[q_wp_reg] <= classified;
        end
    end

endmodule

`default_nettype wire

/* src/pfrb_back.sv */
// Back end: ring storage, pointers, sequence counter, replace scan and result register.
`timescale 1ns / 1ps
`default_nettype none

module pfrb_back import pfrb_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic req_valid,
    output logic      req_ready,
    input  wire req_t req,
    output logic      res_valid,
    input  wire logic res_ready,
    output res_t      res
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    typedef struct packed {
        logic [63:0] data;
        logic [15:0] len;
        logic [31:0] tag;
    } entry_t;

    typedef enum logic [3:0] {
        BK_IDLE = 4'b0001,
        BK_POP  = 4'b0010,
        BK_SCAN = 4'b0100,
        BK_FIN  = 4'b1000
    } bk_state_t;

    entry_t    mem [DEPTH];
    entry_t    rd_data_reg;

    bk_state_t state_reg, state_next;
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] held_reg, held_next;
    logic [31:0]   seq_reg, seq_next;
    logic          primed_reg, primed_next;
    logic [CW-1:0] scan_reg, scan_next;
    logic          cmp_valid_reg, cmp_valid_next;
    logic [AW-1:0] cmp_idx_reg, cmp_idx_next;
    logic [31:0]   key_reg, key_next;
    logic [63:0]   new_data_reg, new_data_next;
    logic [15:0]   new_len_reg, new_len_next;
    status_t       fin_reg, fin_next;
    logic          res_valid_reg, res_valid_next;
    res_t          res_reg, res_next;

    logic          res_free;
    logic          res_load;
    res_t          res_new;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    entry_t        mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;
    logic [CW-1:0] n_written;
    logic          wr_last;
    logic          rd_last;

    assign res_free  = !res_valid_reg || res_ready;
    // entries are first written in index order, so the written set is a prefix
    assign n_written = primed_reg ? CW'(DEPTH) : CW'(wr_ptr_reg);
    assign wr_last   = (wr_ptr_reg == AW'(DEPTH - 1));
    assign rd_last   = (rd_ptr_reg == AW'(DEPTH - 1));
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    always_comb
    begin
        state_next     = state_reg;
        wr_ptr_next    = wr_ptr_reg;
        rd_ptr_next    = rd_ptr_reg;
        held_next      = held_reg;
        seq_next       = seq_reg;
        primed_next    = primed_reg;
        scan_next      = scan_reg;
        cmp_valid_next = cmp_valid_reg;
        cmp_idx_next   = cmp_idx_reg;
        key_next       = key_reg;
        new_data_next  = new_data_reg;
        new_len_next   = new_len_reg;
        fin_next       = fin_reg;
        req_ready      = 1'b0;
        res_load       = 1'b0;
        res_new        = '0;
        mem_we         = 1'b0;
        mem_waddr      = wr_ptr_reg;
        mem_wdata      = '{data: req.data, len: req.len, tag: seq_reg};
        mem_re         = 1'b0;
        mem_raddr      = rd_ptr_reg;

        case (state_reg)
            BK_IDLE:
            begin
                if (req_valid)
                begin
                    case (req.op)
                        CMD_PUSH:
                        begin
                            if (res_free)
                            begin
                                req_ready      = 1'b1;
                                res_load       = 1'b1;
                                res_new.status = ST_OK;
                                if (primed_reg && (held_reg >= CW'(DEPTH - 2)))
                                begin
                                    res_new.status = ST_FULL;
                                end
                                else
                                begin
                                    mem_we      = 1'b1;
                                    held_next   = held_reg + CW'(1);
                                    primed_next = primed_reg || wr_last;
                                    wr_ptr_next = wr_last ? '0 : wr_ptr_reg + AW'(1);
                                    seq_next    = req.given ? req.value : seq_reg + 32'd1;
                                end
                            end
                        end
                        CMD_POP:
                        begin
                            if (!primed_reg || (held_reg == '0))
                            begin
                                if (res_free)
                                begin
                                    req_ready      = 1'b1;
                                    res_load       = 1'b1;
                                    res_new.status = primed_reg ? ST_EMPTY : ST_NOT_PRIMED;
                                end
                            end
                            else
                            begin
                                req_ready  = 1'b1;
                                mem_re     = 1'b1;
                                state_next = BK_POP;
                            end
                        end
                        CMD_REPLACE:
                        begin
                            req_ready      = 1'b1;
                            key_next       = req.value;
                            new_data_next  = req.data;
                            new_len_next   = req.len;
                            scan_next      = '0;
                            cmp_valid_next = 1'b0;
                            state_next     = BK_SCAN;
                        end
                        default:
                        begin
                            if (res_free)
                            begin
                                req_ready      = 1'b1;
                                res_load       = 1'b1;
                                res_new.status = ST_OK;
                            end
                        end
                    endcase
                end
            end
            BK_POP:
            begin
                if (res_free)
                begin
                    res_load       = 1'b1;
                    res_new.status = ST_OK;
                    res_new.data   = rd_data_reg.data;
                    res_new.len    = rd_data_reg.len;
                    res_new.seq    = rd_data_reg.tag;
                    held_next      = held_reg - CW'(1);
                    rd_ptr_next    = rd_last ? '0 : rd_ptr_reg + AW'(1);
                    state_next     = BK_IDLE;
                end
            end
            BK_SCAN:
            begin
                // read of entry k overlaps the tag compare of entry k-1
                if (cmp_valid_reg && (rd_data_reg.tag == key_reg))
                begin
                    mem_we         = 1'b1;
                    mem_waddr      = cmp_idx_reg;
                    mem_wdata      = '{data: new_data_reg, len: new_len_reg, tag: seq_reg};
                    fin_next       = ST_OK;
                    cmp_valid_next = 1'b0;
                    state_next     = BK_FIN;
                end
                else if (scan_reg < n_written)
                begin
                    mem_re         = 1'b1;
                    mem_raddr      = scan_reg[AW-1:0];
                    cmp_valid_next = 1'b1;
                    cmp_idx_next   = scan_reg[AW-1:0];
                    scan_next      = scan_reg + CW'(1);
                end
                else
                begin
                    fin_next       = ST_NO_KEY;
                    cmp_valid_next = 1'b0;
                    state_next     = BK_FIN;
                end
            end
            BK_FIN:
            begin
                if (res_free)
                begin
                    res_load       = 1'b1;
                    res_new.status = fin_reg;
                    state_next     = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase

        res_next       = res_load ? res_new : res_reg;
        res_valid_next = res_load ? 1'b1 : (res_ready ? 1'b0 : res_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            held_reg      <= '0;
            seq_reg       <= '0;
            primed_reg    <= 1'b0;
            scan_reg      <= '0;
            cmp_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wr_ptr_reg    <= wr_ptr_next;
            rd_ptr_reg    <= rd_ptr_next;
            held_reg      <= held_next;
            seq_reg       <= seq_next;
            primed_reg    <= primed_next;
            scan_reg      <= scan_next;
            cmp_valid_reg <= cmp_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmp_idx_reg  <= cmp_idx_next;
        key_reg      <= key_next;
        new_data_reg <= new_data_next;
        new_len_reg  <= new_len_next;
        fin_reg      <= fin_next;
        res_reg      <= res_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

endmodule

`default_nettype wire

/* src/primed_frame_ring_buffer.sv */
// Top level of the primed frame ring buffer.
//
//  channel  dir  tdata (low bit up)                       tuser (low bit up)
//  s_axis   in   frame_data 64, frame_len 16, seq_value 32  cmd 2, seq_given 1
//  m_axis   out  out_data 64, out_len 16, out_seq 32        status 3
//
// Push and no-op are answered from the idle state of the back end; a pop goes
// through a registered read of the single ring memory port. Replace scans the
// written entries, one tag read per cycle through the same port.
// Reset clears pointers, counters and flags; the ring memory is not cleared.
// A 2-deep request queue and the result register let each side stall alone.
`timescale 1ns / 1ps
`default_nettype none

module primed_frame_ring_buffer import pfrb_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          s_axis_tvalid,
    output logic               s_axis_tready,
    input  wire logic [111:0]  s_axis_tdata,   // frame_data, frame_len, seq_value
    input  wire logic [2:0]    s_axis_tuser,   // cmd, seq_given
    output logic               m_axis_tvalid,
    input  wire logic          m_axis_tready,
    output logic [111:0]       m_axis_tdata,   // out_data, out_len, out_seq
    output logic [2:0]         m_axis_tuser    // status
);

    logic req_valid;
    logic req_ready;
    req_t req;
    res_t res;

    pfrb_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_cmd    (s_axis_tuser[1:0]),
        .in_data   (s_axis_tdata[63:0]),
        .in_len    (s_axis_tdata[79:64]),
        .in_given  (s_axis_tuser[2]),
        .in_value  (s_axis_tdata[111:80]),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req)
    );

    pfrb_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .res_valid (m_axis_tvalid),
        .res_ready (m_axis_tready),
        .res       (res)
    );

    assign m_axis_tdata = {res.seq, res.len, res.data};
    assign m_axis_tuser = res.status;

endmodule

`default_nettype wire

/* src/pfrb_checker.sv */
// Port-level assertions for the primed frame ring buffer, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module pfrb_checker import pfrb_pkg::*;
(
    input wire logic         clk,
    input wire logic         rst_n,
    input wire logic         s_axis_tvalid,
    input wire logic         s_axis_tready,
    input wire logic         m_axis_tvalid,
    input wire logic         m_axis_tready,
    input wire logic [111:0] m_axis_tdata,
    input wire logic [2:0]   m_axis_tuser
);

    // queue, one request in the back end and the result register
    localparam logic [3:0] OUT_MAX = 4'd4;

    logic [3:0] outstanding_reg;
    logic       s_acc;
    logic       m_acc;

    assign s_acc = s_axis_tvalid && s_axis_tready;
    assign m_acc = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            outstanding_reg <= 4'd0;
        end
        else
        begin
            outstanding_reg <= outstanding_reg + {3'd0, s_acc} - {3'd0, m_acc};
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        m_acc |-> outstanding_reg != 4'd0)
        else $error("result delivered with no request outstanding");

    a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        outstanding_reg <= OUT_MAX)
        else $error("more requests in flight than the buffering holds");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser != ST_OK) |-> m_axis_tdata == 112'd0)
        else $error("refused request carries frame data");

endmodule

bind primed_frame_ring_buffer pfrb_checker u_pfrb_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
